@@ rtl/lrupc_pkg.sv @@
// ----------------------------------------------------------------------------
// lrupc_pkg
// Shared types and constants of the prefer-clean LRU replacement unit.
// ----------------------------------------------------------------------------
package lrupc_pkg;

    // request kinds carried in tuser
    localparam logic REQ_ACCESS = 1'b0;
    localparam logic REQ_QUERY  = 1'b1;

    // configuration register map
    localparam int  APB_AW          = 3;
    localparam logic REG_PREFER_CLEAN = 1'b0;  // word index, paddr[2]

    // input tdata layout
    localparam int SET_W   = 6;
    localparam int MASK_W  = 8;
    localparam int IN_DW   = 24;
    localparam int SET_LSB = 0;
    localparam int HIT_LSB = 6;
    localparam int DRT_LSB = 14;

    // output tdata layout
    localparam int VWAY_W = 3;
    localparam int OUT_DW = 8;

    // widest set address and way number over the parameter ranges
    localparam int SET_EXT_W = 13;
    localparam int WAY_EXT_W = 4;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic clr_step;
        logic load;
        logic exec;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic clr_last;
        logic out_free;
    } t_sts;

endpackage

@@ rtl/lrupc_ram.sv @@
// ----------------------------------------------------------------------------
// lrupc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module lrupc_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/lrupc_ctrl.sv @@
// ----------------------------------------------------------------------------
// lrupc_ctrl
// Sequencer: clearing sweep after reset, then one request at a time in a
// read cycle followed by an update cycle.
// ----------------------------------------------------------------------------
module lrupc_ctrl
    import lrupc_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_s_tvalid,
    output logic   o_s_tready,
    input  t_sts   i_sts,
    output t_cmd   o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: begin
                if (i_sts.clr_last) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (i_s_tvalid && i_sts.out_free) n_state = ST_EXEC;
            end
            ST_EXEC: begin
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase
    end

    always_comb begin
        o_s_tready   = 1'b0;
        o_cmd        = '0;
        case (r_state)
            ST_CLEAR: begin
                o_cmd.clr_step = 1'b1;
            end
            ST_IDLE: begin
                o_s_tready = i_sts.out_free;
                o_cmd.load = i_s_tvalid && i_sts.out_free;
            end
            ST_EXEC: begin
                o_cmd.exec = 1'b1;
            end
            default: begin
                o_s_tready = 1'b0;
            end
        endcase
    end

endmodule

@@ rtl/lrupc_dp.sv @@
// ----------------------------------------------------------------------------
// lrupc_dp
// Datapath: recency memory, request latch, promotion and victim selection,
// write-back forwarding and the result register.
// ----------------------------------------------------------------------------
module lrupc_dp
    import lrupc_pkg::*;
#(
    parameter int SET_COUNT = 64,
    parameter int WAYS      = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cmd              i_cmd,
    output t_sts              o_sts,
    input  logic              i_prefer_clean,
    input  logic [IN_DW-1:0]  i_s_tdata,
    input  logic              i_s_tuser,
    output logic              o_m_tvalid,
    input  logic              i_m_tready,
    output logic [OUT_DW-1:0] o_m_tdata
);

    localparam int WW = $clog2(WAYS);
    localparam int OW = WAYS * WW;
    localparam int SW = (SET_COUNT > 1) ? $clog2(SET_COUNT) : 1;

    typedef logic [WW-1:0] t_way;

    // request latch
    logic              r_req;
    logic [SET_W-1:0]  r_set;
    logic [MASK_W-1:0] r_hit;
    logic [MASK_W-1:0] r_dirty;

    // clearing sweep
    logic [SW-1:0] r_clr_cnt;

    // last word written back
    logic          r_fwd_vld;
    logic [SW-1:0] r_fwd_addr;
    logic [OW-1:0] r_fwd_word;

    // result register
    logic              r_out_vld;
    logic [VWAY_W-1:0] r_victim;
    logic              r_modified;

    logic [SET_EXT_W-1:0] in_set_ext;
    logic [SET_EXT_W-1:0] set_ext;
    logic [SW-1:0]        in_addr;
    logic [SW-1:0]        cur_addr;
    logic                 set_ok;
    logic [OW-1:0]        id_word;
    logic [OW-1:0]        rd_word;
    logic [OW-1:0]        cur_word;
    logic [OW-1:0]        new_word;
    t_way                 ord     [WAYS];
    t_way                 qord    [WAYS];
    logic [15:0]          hit16;
    logic                 hit_fnd;
    t_way                 hit_way;
    logic [WAY_EXT_W-1:0] pos;
    logic [WAYS-1:0]      clean;
    t_way                 victim;
    logic [WAY_EXT_W-1:0] victim_ext;
    logic [WAY_EXT_W-1:0] tmp_ext;
    logic                 upd_we;
    logic                 ram_we;
    logic [SW-1:0]        ram_waddr;
    logic [OW-1:0]        ram_wdata;

    assign in_set_ext = SET_EXT_W'(i_s_tdata[SET_LSB +: SET_W]);
    assign set_ext    = SET_EXT_W'(r_set);
    assign in_addr    = in_set_ext[SW-1:0];
    assign cur_addr   = set_ext[SW-1:0];
    assign set_ok     = set_ext < SET_EXT_W'(SET_COUNT);

    always_comb begin
        for (int j = 0; j < WAYS; j++) begin
            id_word[j*WW +: WW] = t_way'(j);
        end
    end

    // the write-back is already in the RAM by the time the next read issues
    assign cur_word = (r_fwd_vld && r_fwd_addr == cur_addr) ? r_fwd_word : rd_word;

    always_comb begin
        for (int j = 0; j < WAYS; j++) begin
            ord[j]  = cur_word[j*WW +: WW];
            qord[j] = set_ok ? cur_word[j*WW +: WW] : id_word[j*WW +: WW];
        end
    end

    // lowest matching way
    assign hit16 = 16'(r_hit);
    always_comb begin
        hit_fnd = 1'b0;
        hit_way = '0;
        for (int j = WAYS - 1; j >= 0; j--) begin
            if (hit16[j]) begin
                hit_fnd = 1'b1;
                hit_way = t_way'(j);
            end
        end
    end

    // position of that way in the order
    always_comb begin
        pos = '0;
        for (int j = WAYS - 1; j >= 0; j--) begin
            if (ord[j] == hit_way) pos = WAY_EXT_W'(j);
        end
    end

    // move to front
    always_comb begin
        for (int j = 0; j < WAYS; j++) begin
            if (j == 0) begin
                new_word[j*WW +: WW] = hit_way;
            end else if (WAY_EXT_W'(j) <= pos) begin
                new_word[j*WW +: WW] = ord[j-1];
            end else begin
                new_word[j*WW +: WW] = ord[j];
            end
        end
    end

    // ways numbered 8 and up count as clean
    always_comb begin
        for (int j = 0; j < WAYS; j++) begin
            tmp_ext  = WAY_EXT_W'(qord[j]);
            clean[j] = tmp_ext[WAY_EXT_W-1] ? 1'b1 : !r_dirty[tmp_ext[VWAY_W-1:0]];
        end
    end

    always_comb begin
        victim = qord[WAYS-1];
        if (i_prefer_clean) begin
            for (int j = 0; j < WAYS; j++) begin
                if (clean[j]) victim = qord[j];
            end
        end
    end

    assign victim_ext = WAY_EXT_W'(victim);

    assign upd_we    = i_cmd.exec && (r_req == REQ_ACCESS) && set_ok && hit_fnd;
    assign ram_we    = i_cmd.clr_step || upd_we;
    assign ram_waddr = i_cmd.clr_step ? r_clr_cnt : cur_addr;
    assign ram_wdata = i_cmd.clr_step ? id_word : new_word;

    lrupc_ram #(
        .WIDTH (OW),
        .DEPTH (SET_COUNT),
        .AW    (SW)
    ) u_order_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (i_cmd.load),
        .i_raddr (in_addr),
        .o_rdata (rd_word)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req   <= i_s_tuser;
            r_set   <= i_s_tdata[SET_LSB +: SET_W];
            r_hit   <= i_s_tdata[HIT_LSB +: MASK_W];
            r_dirty <= i_s_tdata[DRT_LSB +: MASK_W];
        end
        if (upd_we) begin
            r_fwd_addr <= cur_addr;
            r_fwd_word <= new_word;
        end
        if (i_cmd.exec && r_req == REQ_QUERY) begin
            r_victim   <= victim_ext[VWAY_W-1:0];
            r_modified <= !victim_ext[WAY_EXT_W-1] && r_dirty[victim_ext[VWAY_W-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_cnt <= '0;
            r_fwd_vld <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (i_cmd.clr_step) r_clr_cnt <= r_clr_cnt + 1'b1;
            if (i_cmd.clr_step) begin
                r_fwd_vld <= 1'b0;
            end else if (upd_we) begin
                r_fwd_vld <= 1'b1;
            end
            if (i_cmd.exec && r_req == REQ_QUERY) begin
                r_out_vld <= 1'b1;
            end else if (i_m_tready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    assign o_sts.clr_last = r_clr_cnt == SW'(SET_COUNT - 1);
    assign o_sts.out_free = !r_out_vld || i_m_tready;

    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = OUT_DW'({r_modified, r_victim});

endmodule

@@ rtl/lru_prefer_clean_replacement_unit.sv @@
// ----------------------------------------------------------------------------
// lru_prefer_clean_replacement_unit
// Per-set true-LRU replacement engine with optional least-recent-clean
// victim choice.
// ----------------------------------------------------------------------------
//  channel   dir  handshake              contents
//  s (req)   in   i_s_tvalid/o_s_tready  tuser req_type, tdata set/hit/dirty
//  m (vict)  out  o_m_tvalid/i_m_tready  tdata victim_way, victim_modified
//  apb       in   psel/penable/pready    prefer_clean at byte address 0
//
//  every request first reads the set's recency word from the synchronous
//  RAM, then reorders and writes it back or picks the victim.
//  after reset a sweep writes the identity order into all SET_COUNT sets;
//  o_s_tready stays low until the sweep ends.
//  a victim waits in the output register; a new request is taken only when
//  that register is empty or drains in the same cycle.
// ----------------------------------------------------------------------------
module lru_prefer_clean_replacement_unit
    import lrupc_pkg::*;
#(
    parameter int SET_COUNT = 64,
    parameter int WAYS      = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_tvalid,
    output logic              o_s_tready,
    input  logic [IN_DW-1:0]  i_s_tdata,   // set_index, hit_mask, dirty_mask, pad
    input  logic              i_s_tuser,   // req_type
    output logic              o_m_tvalid,
    input  logic              i_m_tready,
    output logic [OUT_DW-1:0] o_m_tdata,   // victim_way, victim_modified, pad
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    logic r_prefer_clean;
    t_cmd cmd;
    t_sts sts;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prefer_clean <= 1'b0;
        end else if (psel && penable && pwrite && pready && paddr[2] == REG_PREFER_CLEAN) begin
            r_prefer_clean <= pwdata[0];
        end
    end

    assign prdata = (paddr[2] == REG_PREFER_CLEAN) ? {31'b0, r_prefer_clean} : 32'b0;

    lrupc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    lrupc_dp #(
        .SET_COUNT (SET_COUNT),
        .WAYS      (WAYS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .i_prefer_clean (r_prefer_clean),
        .i_s_tdata      (i_s_tdata),
        .i_s_tuser      (i_s_tuser),
        .o_m_tvalid     (o_m_tvalid),
        .i_m_tready     (i_m_tready),
        .o_m_tdata      (o_m_tdata)
    );

    // one request in flight at a time
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> !o_s_tready)
        else $error("request taken during update cycle");

    // a query yields a victim, registered in the result register by ST_EXEC
    a_query_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready && i_s_tuser == REQ_QUERY) |=> ##1 o_m_tvalid)
        else $error("victim missing after query");

    // an access never produces a result
    a_access_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready && i_s_tuser == REQ_ACCESS && !o_m_tvalid)
        |=> ##1 !o_m_tvalid)
        else $error("result produced by access");

endmodule

@@ tb/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the prefer-clean LRU replacement unit. Access and
// victim-query transfers stream in with random bursts and gaps while the
// victim side stalls on its own pattern. A per-set recency model predicts
// every victim, and each victim transfer is compared field by field. The
// prefer_clean register is rewritten between phases while the unit is idle.
// ----------------------------------------------------------------------------
module testbench
    import lrupc_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int N_SETS = 64;
    localparam int N_WAYS = 8;
    localparam logic [APB_AW-1:0] ADDR_PREFER_CLEAN = {REG_PREFER_CLEAN, 2'b00};
    localparam logic [APB_AW-1:0] ADDR_UNMAPPED     = 3'd4;
    localparam int SETTLE_CYCLES = 8;

    typedef struct {
        logic [VWAY_W-1:0] way;
        logic              modified;
    } t_victim_rec;

    // recency model of every set, plus the victims still owed by the unit
    class victim_predictor;
        logic [VWAY_W-1:0] recency [N_SETS][N_WAYS];
        bit                prefer_clean;
        t_victim_rec       expected_victims [$];
        int                errors;

        function new();
            for (int s = 0; s < N_SETS; s++) begin
                for (int j = 0; j < N_WAYS; j++) begin
                    recency[s][j] = VWAY_W'(j);
                end
            end
            prefer_clean = 1'b0;
            errors = 0;
        endfunction

        function void write_reg(int index, logic [31:0] value);
            if (index == REG_PREFER_CLEAN) begin
                prefer_clean = value[0];
            end
        endfunction

        function void note_request(logic req, logic [SET_W-1:0] set_idx,
                                   logic [MASK_W-1:0] hit, logic [MASK_W-1:0] dirty);
            int hit_way;
            int pos;
            t_victim_rec rec;
            if (req == REQ_ACCESS) begin
                hit_way = -1;
                for (int j = 0; j < N_WAYS; j++) begin
                    if (hit[j] && hit_way < 0) hit_way = j;
                end
                if (hit_way < 0) return;
                pos = -1;
                for (int j = 0; j < N_WAYS; j++) begin
                    if (recency[set_idx][j] == hit_way && pos < 0) pos = j;
                end
                for (int j = pos; j > 0; j--) begin
                    recency[set_idx][j] = recency[set_idx][j-1];
                end
                recency[set_idx][0] = VWAY_W'(hit_way);
            end else begin
                rec.way = recency[set_idx][N_WAYS-1];
                if (prefer_clean) begin
                    // walk from the least recent end, first clean way wins
                    for (int j = N_WAYS - 1; j >= 0; j--) begin
                        if (!dirty[recency[set_idx][j]]) begin
                            rec.way = recency[set_idx][j];
                            break;
                        end
                    end
                end
                rec.modified = dirty[rec.way];
                expected_victims.push_back(rec);
            end
        endfunction

        function void check_victim(logic [VWAY_W-1:0] way, logic modified);
            t_victim_rec rec;
            if (expected_victims.size() == 0) begin
                $error("victim transfer with nothing expected: way %0d", way);
                errors++;
                return;
            end
            rec = expected_victims.pop_front();
            if (way !== rec.way) begin
                $error("victim_way mismatch: expected %0d, actual %0d", rec.way, way);
                errors++;
            end
            if (modified !== rec.modified) begin
                $error("victim_modified mismatch: expected %0d, actual %0d",
                       rec.modified, modified);
                errors++;
            end
        endfunction
    endclass

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [IN_DW-1:0]  s_tdata = '0;   // set_index, hit_mask, dirty_mask, pad
    logic              s_tuser = 1'b0; // req_type
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [OUT_DW-1:0] m_tdata;        // victim_way, victim_modified, pad
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [APB_AW-1:0] paddr = '0;
    logic [31:0]       pwdata = '0;
    logic [31:0]       prdata;
    logic              pready;

    int hold_seq = 0;

    victim_predictor sb = new();

    lru_prefer_clean_replacement_unit #(
        .SET_COUNT (N_SETS),
        .WAYS      (N_WAYS)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    initial begin
        #2_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    // victim side: stall pattern is re-picked whenever its random run length expires
    initial begin : victim_sink
        int mode;
        int left;
        int hold;
        int seen;
        mode = 0;
        left = 0;
        hold = 0;
        seen = 0;
        forever begin
            @(negedge i_clk);
            if (hold_seq != seen) begin
                seen = hold_seq;
                hold = 400;
            end
            if (left == 0) begin
                mode = $urandom_range(0, 3);
                left = $urandom_range(20, 120);
            end
            left--;
            if (hold > 0) begin
                hold--;
                m_tready <= 1'b0;
            end else begin
                case (mode)
                    0: m_tready <= 1'b1;
                    1: m_tready <= 1'($urandom_range(0, 1));
                    2: m_tready <= ($urandom_range(0, 3) == 0);
                    default: m_tready <= ~m_tready;
                endcase
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_tvalid && m_tready) begin
            sb.check_victim(m_tdata[VWAY_W-1:0], m_tdata[VWAY_W]);
        end
    end

    task automatic send_request(logic req, logic [SET_W-1:0] set_idx,
                                logic [MASK_W-1:0] hit, logic [MASK_W-1:0] dirty);
        logic [IN_DW-1:0] word;
        word = '0;
        word[SET_LSB +: SET_W] = set_idx;
        word[HIT_LSB +: MASK_W] = hit;
        word[DRT_LSB +: MASK_W] = dirty;
        @(negedge i_clk);
        s_tvalid <= 1'b1;
        s_tuser <= req;
        s_tdata <= word;
        do @(posedge i_clk); while (!s_tready);
        sb.note_request(req, set_idx, hit, dirty);
    endtask

    task automatic pause_sender(int cycles);
        @(negedge i_clk);
        s_tvalid <= 1'b0;
        repeat (cycles - 1) @(negedge i_clk);
    endtask

    // drop valid, let all victims come back and the pipeline go quiet
    task automatic wait_idle();
        pause_sender(1);
        while (sb.expected_victims.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic apb_write(logic [APB_AW-1:0] addr, logic [31:0] data);
        @(negedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        sb.write_reg(int'(addr >> 2), data);
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic run_random_phase(int count);
        int sent;
        int burst;
        int gap_max;
        int pick;
        logic req;
        logic [SET_W-1:0] set_idx;
        logic [MASK_W-1:0] hit;
        logic [MASK_W-1:0] dirty;
        sent = 0;
        while (sent < count) begin
            burst = $urandom_range(1, 20);
            gap_max = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 6);
            for (int b = 0; b < burst && sent < count; b++) begin
                req = ($urandom_range(0, 99) < 35) ? REQ_QUERY : REQ_ACCESS;
                // a few hot sets keep same-set back-to-back requests frequent
                set_idx = $urandom_range(0, 1) ? SET_W'($urandom_range(0, 3))
                                               : SET_W'($urandom_range(0, N_SETS - 1));
                pick = $urandom_range(0, 99);
                if (pick < 70) hit = MASK_W'(1) << $urandom_range(0, N_WAYS - 1);
                else if (pick < 85) hit = MASK_W'($urandom_range(0, 255));
                else if (pick < 95) hit = '0;
                else hit = '1;
                pick = $urandom_range(0, 99);
                if (pick < 15) dirty = '1;
                else if (pick < 25) dirty = '0;
                else if (pick < 40) dirty = ~(MASK_W'(1) << $urandom_range(0, N_WAYS - 1));
                else dirty = MASK_W'($urandom_range(0, 255));
                send_request(req, set_idx, hit, dirty);
                sent++;
            end
            if (gap_max > 0) pause_sender($urandom_range(1, gap_max));
        end
    endtask

    initial begin : stimulus
        int wait_left;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        apb_write(ADDR_PREFER_CLEAN, 32'h0);

        // plain lru on the reset order, promotions, no-hit and multi-hit accesses
        send_request(REQ_QUERY,  6'd0,  8'h00, 8'h00);
        send_request(REQ_ACCESS, 6'd0,  8'h00, 8'hFF);
        send_request(REQ_ACCESS, 6'd0,  8'hFF, 8'h00);
        send_request(REQ_ACCESS, 6'd0,  8'h80, 8'h00);
        send_request(REQ_QUERY,  6'd0,  8'h00, 8'hFF);
        send_request(REQ_ACCESS, 6'd0,  8'h06, 8'h00);
        send_request(REQ_QUERY,  6'd0,  8'hFF, 8'h00);
        send_request(REQ_ACCESS, 6'd63, 8'h40, 8'h00);
        send_request(REQ_QUERY,  6'd63, 8'h00, 8'hFF);
        wait_idle();

        // prefer clean: all dirty falls back to lru, otherwise least recent clean
        apb_write(ADDR_PREFER_CLEAN, 32'hFFFF_FFFF);
        send_request(REQ_QUERY,  6'd0,  8'h00, 8'hFF);
        send_request(REQ_QUERY,  6'd0,  8'h00, 8'h7F);
        send_request(REQ_QUERY,  6'd63, 8'h00, 8'h00);
        send_request(REQ_QUERY,  6'd0,  8'h00, 8'h40);
        send_request(REQ_ACCESS, 6'd5,  8'h01, 8'h00);
        send_request(REQ_QUERY,  6'd5,  8'h00, 8'h55);
        wait_idle();

        // unmapped address must leave the register alone
        apb_write(ADDR_UNMAPPED, 32'h0);
        send_request(REQ_QUERY,  6'd0,  8'h00, 8'hBF);
        wait_idle();
        apb_write(ADDR_PREFER_CLEAN, 32'hFFFF_FFFE);
        send_request(REQ_QUERY,  6'd0,  8'h00, 8'hFF);

        for (int p = 0; p < 6; p++) begin
            wait_idle();
            apb_write(ADDR_PREFER_CLEAN, (p % 2 == 0) ? 32'h1 : 32'h0);
            run_random_phase(195);
        end

        // victim side holds off while queries keep coming, so the input backs up
        wait_idle();
        hold_seq++;
        for (int k = 0; k < 40; k++) begin
            send_request(REQ_QUERY, SET_W'($urandom_range(0, N_SETS - 1)),
                         MASK_W'($urandom_range(0, 255)), MASK_W'($urandom_range(0, 255)));
        end
        wait_idle();
        run_random_phase(60);

        pause_sender(1);
        wait_left = 20000;
        while (sb.expected_victims.size() != 0 && wait_left > 0) begin
            @(posedge i_clk);
            wait_left--;
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (sb.expected_victims.size() != 0) begin
            $error("%0d expected victims never arrived", sb.expected_victims.size());
            sb.errors++;
        end
        if (sb.errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/lrupc_pkg.sv
rtl/lrupc_ram.sv
rtl/lrupc_ctrl.sv
rtl/lrupc_dp.sv
rtl/lru_prefer_clean_replacement_unit.sv
tb/testbench.sv
